[sv/mfe_pkg.sv]
// Shared types and constants for the message frame encoder.
package mfe_pkg;

  localparam int IN_DATA_W  = 112;
  localparam int CFG_IDX_W  = 8;
  localparam int BL_W       = 16;
  localparam int TOTAL_W    = 17;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam int MAX_TEXT_LEN = 512;
  localparam int MAX_DATA_LEN = 65535;

  localparam logic [TOTAL_W-1:0] FIXED_OVERHEAD = TOTAL_W'(26);
  localparam logic [31:0]        CHECKSUM_WORD  = 32'd1;

  localparam logic [7:0] START_BYTE_RST = 8'd2;
  localparam logic [7:0] END_BYTE_RST   = 8'd3;

  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_END_BYTE   = CFG_IDX_W'(1);

  localparam logic OP_HEADER  = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  // Output byte positions within one request's expansion
  localparam logic [4:0] SL_START   = 5'd0;
  localparam logic [4:0] SL_TOTAL   = 5'd1;
  localparam logic [4:0] SL_ID      = 5'd5;
  localparam logic [4:0] SL_NAMELEN = 5'd9;
  localparam logic [4:0] SL_BYTE    = 5'd13;
  localparam logic [4:0] SL_ERR     = 5'd14;
  localparam logic [4:0] SL_TLEN    = 5'd18;
  localparam logic [4:0] SL_CSUM    = 5'd22;
  localparam logic [4:0] SL_END     = 5'd26;

  typedef struct packed {
    logic               is_header;
    logic               has_ins;
    logic               has_close;
    logic [7:0]         data_byte;
    logic [31:0]        msg_id;
    logic [TOTAL_W-1:0] total;
    logic [9:0]         name_len;
    logic [31:0]        err_code;
    logic [9:0]         text_len;
  } cmd_t;

endpackage

[sv/mfe_front.sv]
// Front end: accepts requests, tracks frame phase and issues commands.
module mfe_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  input  logic [31:0]         in_message_id,
  input  logic signed [31:0]  in_error_code,
  input  logic [9:0]          in_name_length,
  input  logic [9:0]          in_text_length,
  input  logic [15:0]         in_data_length,
  input  logic [7:0]          in_payload_byte,
  input  logic                q_full,
  output logic                push,
  output mfe_pkg::cmd_t       cmd
);
  import mfe_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_NAME, PH_TEXT, PH_DATA} phase_t;

  phase_t            phase_r, phase_nxt;
  logic [BL_W-1:0]   bl_r, bl_nxt;
  logic [31:0]       held_ec_r, held_ec_nxt;
  logic [9:0]        held_tl_r, held_tl_nxt;
  logic [15:0]       held_dl_r, held_dl_nxt;
  logic              too_long;

  assign in_ready = !q_full;
  assign too_long = (32'(in_text_length) > 32'(MAX_TEXT_LEN)) ||
                    (32'(in_data_length) > 32'(MAX_DATA_LEN));

  always_comb begin
    phase_nxt   = phase_r;
    bl_nxt      = bl_r;
    held_ec_nxt = held_ec_r;
    held_tl_nxt = held_tl_r;
    held_dl_nxt = held_dl_r;
    push        = 1'b0;
    cmd         = '0;
    if (in_valid && in_ready) begin
      if (in_op == OP_HEADER) begin
        if (phase_r == PH_IDLE && !too_long) begin
          push          = 1'b1;
          cmd.is_header = 1'b1;
          cmd.msg_id    = in_message_id;
          cmd.total     = FIXED_OVERHEAD + TOTAL_W'(in_name_length)
                          + TOTAL_W'(in_text_length) + TOTAL_W'(in_data_length);
          cmd.name_len  = in_name_length;
          cmd.err_code  = in_error_code;
          cmd.text_len  = in_text_length;
          held_ec_nxt   = in_error_code;
          held_tl_nxt   = in_text_length;
          held_dl_nxt   = in_data_length;
          if (in_name_length != '0) begin
            phase_nxt = PH_NAME;
            bl_nxt    = BL_W'(in_name_length);
          end else begin
            cmd.has_ins = 1'b1;
            if (in_text_length != '0) begin
              phase_nxt = PH_TEXT;
              bl_nxt    = BL_W'(in_text_length);
            end else if (in_data_length != '0) begin
              phase_nxt = PH_DATA;
              bl_nxt    = BL_W'(in_data_length);
            end else begin
              cmd.has_close = 1'b1;
            end
          end
        end
      end else if (phase_r != PH_IDLE) begin
        push          = 1'b1;
        cmd.data_byte = in_payload_byte;
        cmd.err_code  = held_ec_r;
        cmd.text_len  = held_tl_r;
        bl_nxt        = bl_r - BL_W'(1);
        if (bl_r == BL_W'(1)) begin
          unique case (phase_r)
            PH_NAME: begin
              cmd.has_ins = 1'b1;
              if (held_tl_r != '0) begin
                phase_nxt = PH_TEXT;
                bl_nxt    = BL_W'(held_tl_r);
              end else if (held_dl_r != '0) begin
                phase_nxt = PH_DATA;
                bl_nxt    = held_dl_r;
              end else begin
                cmd.has_close = 1'b1;
                phase_nxt     = PH_IDLE;
              end
            end
            PH_TEXT: begin
              if (held_dl_r != '0) begin
                phase_nxt = PH_DATA;
                bl_nxt    = held_dl_r;
              end else begin
                cmd.has_close = 1'b1;
                phase_nxt     = PH_IDLE;
              end
            end
            PH_DATA: begin
              cmd.has_close = 1'b1;
              phase_nxt     = PH_IDLE;
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bl_r      <= '0;
      held_ec_r <= '0;
      held_tl_r <= '0;
      held_dl_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      bl_r      <= bl_nxt;
      held_ec_r <= held_ec_nxt;
      held_tl_r <= held_tl_nxt;
      held_dl_r <= held_dl_nxt;
    end
  end

endmodule

[sv/mfe_queue.sv]
// Small command queue between the front end and the byte sequencer.
module mfe_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mfe_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output mfe_pkg::cmd_t  head_cmd
);
  import mfe_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

[sv/mfe_back.sv]
// Byte sequencer: expands each command into frame bytes on the output stream.
module mfe_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [7:0]     start_byte,
  input  logic [7:0]     end_byte,
  input  logic           head_valid,
  input  mfe_pkg::cmd_t  head_cmd,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_data,
  output logic           out_last
);
  import mfe_pkg::*;

  logic [4:0] slot_r, slot_nxt;
  logic       fresh_r, fresh_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r, out_data_nxt;
  logic       out_last_r, out_last_nxt;
  logic [4:0] cur_slot, cand;
  logic       done, emit;
  logic [31:0] word;
  logic [4:0] base;
  logic [1:0] sel;
  logic [7:0] sbyte;

  assign cur_slot = fresh_r ? (head_cmd.is_header ? SL_START : SL_BYTE) : slot_r;
  assign emit     = head_valid && (!out_valid_r || out_ready);
  assign pop      = emit && done;

  always_comb begin
    cand = cur_slot + 5'd1;
    done = 1'b0;
    if (cand == SL_BYTE && head_cmd.is_header) begin
      cand = SL_ERR;
    end
    if (cand == SL_ERR && !head_cmd.has_ins) begin
      cand = SL_CSUM;
    end
    if (cand == SL_CSUM && !head_cmd.has_close) begin
      done = 1'b1;
    end
    if (cur_slot == SL_END) begin
      done = 1'b1;
    end
  end

  always_comb begin
    word  = '0;
    base  = SL_START;
    sbyte = '0;
    if (cur_slot < SL_ID) begin
      word = 32'(head_cmd.total);
      base = SL_TOTAL;
    end else if (cur_slot < SL_NAMELEN) begin
      word = head_cmd.msg_id;
      base = SL_ID;
    end else if (cur_slot < SL_BYTE) begin
      word = 32'(head_cmd.name_len);
      base = SL_NAMELEN;
    end else if (cur_slot < SL_TLEN) begin
      word = head_cmd.err_code;
      base = SL_ERR;
    end else if (cur_slot < SL_CSUM) begin
      word = 32'(head_cmd.text_len);
      base = SL_TLEN;
    end else begin
      word = CHECKSUM_WORD;
      base = SL_CSUM;
    end
    sel   = 2'd3 - 2'(cur_slot - base);
    sbyte = word[{sel, 3'b000} +: 8];
    if (cur_slot == SL_START) begin
      sbyte = start_byte;
    end else if (cur_slot == SL_BYTE) begin
      sbyte = head_cmd.data_byte;
    end else if (cur_slot == SL_END) begin
      sbyte = end_byte;
    end
  end

  always_comb begin
    slot_nxt      = slot_r;
    fresh_nxt     = fresh_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = sbyte;
      out_last_nxt  = (cur_slot == SL_END);
      fresh_nxt     = done;
      slot_nxt      = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= SL_START;
      fresh_r     <= 1'b1;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      slot_r      <= slot_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

endmodule

[sv/message_frame_encoder.sv]
// Message frame encoder: turns a header request and its payload bytes into a
// length-prefixed byte frame. A header request yields 13 bytes (start byte,
// big-endian total length, id and name length) and up to 26 when all sections
// are empty; each payload request yields its byte plus any inserted error code,
// text length, checksum word and end byte. The output carries one byte per
// cycle while out_tready allows, set by the byte sequencer, so each request
// holds it for as many bytes as it yields. A 4-entry command queue lets the
// input keep accepting during that time; an accepted request is written into
// the queue and its first byte is registered by the byte sequencer from the
// queue head. Configuration writes are always accepted.
module message_frame_encoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // message_id[31:0], error_code[63:32], name_length[73:64],
  // text_length[83:74], data_length[99:84], payload_byte[107:100], zero pad
  input  logic [mfe_pkg::IN_DATA_W-1:0]    in_tdata,
  // operation
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_byte[7:0]
  output logic [7:0]                       out_tdata,
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mfe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [7:0]                       cfg_data
);
  import mfe_pkg::*;

  logic [7:0] start_byte_r, end_byte_r;
  logic       push, q_full, pop, head_valid;
  cmd_t       push_cmd, head_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RST;
      end_byte_r   <= END_BYTE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_BYTE: start_byte_r <= cfg_data;
        REG_END_BYTE:   end_byte_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mfe_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .in_op           (in_tuser),
    .in_message_id   (in_tdata[31:0]),
    .in_error_code   (signed'(in_tdata[63:32])),
    .in_name_length  (in_tdata[73:64]),
    .in_text_length  (in_tdata[83:74]),
    .in_data_length  (in_tdata[99:84]),
    .in_payload_byte (in_tdata[107:100]),
    .q_full          (q_full),
    .push            (push),
    .cmd             (push_cmd)
  );

  mfe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  mfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_byte (start_byte_r),
    .end_byte   (end_byte_r),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

[sv/mfe_checker.sv]
// Port-level checks for the message frame encoder, bound to the top level.
module mfe_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [7:0]                       out_tdata,
  input  logic                             out_tlast,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [mfe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [7:0]                       cfg_data
);
  import mfe_pkg::*;

  logic [7:0] end_shadow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_shadow_r <= END_BYTE_RST;
    end else if (cfg_valid && cfg_ready && cfg_index == REG_END_BYTE) begin
      end_shadow_r <= cfg_data;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration request refused");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output changed");

  a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata == end_shadow_r)
    else $error("last byte is not the end byte");

endmodule

bind message_frame_encoder mfe_checker u_mfe_checker (.*);

[verif/frame_checker.sv]
`timescale 1ns / 1ps
// Scoreboard that predicts the encoder's frame bytes from the requests it accepts.
module frame_checker
  import mfe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tuser,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [7:0]           out_tdata,
  input  logic                 out_tlast,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   fail_count,
  output int                   pending,
  output int                   bytes_seen,
  output int                   frames_seen
);

  typedef enum logic [1:0] {SEG_IDLE, SEG_NAME, SEG_TEXT, SEG_DATA} seg_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } frame_byte_t;

  frame_byte_t bytes_due[$];
  seg_t        seg;
  logic [16:0] seg_left;
  logic [31:0] kept_err;
  logic [9:0]  kept_text_len;
  logic [16:0] kept_data_len;
  logic [7:0]  open_byte;
  logic [7:0]  close_byte;
  int          err_n;
  int          byte_n;
  int          frame_n;

  task automatic push_byte(input logic [7:0] v, input logic last);
    frame_byte_t b;
    b.value = v;
    b.last  = last;
    bytes_due = {bytes_due, b};
  endtask

  task automatic push_word(input logic [31:0] w);
    push_byte(w[31:24], 1'b0);
    push_byte(w[23:16], 1'b0);
    push_byte(w[15:8], 1'b0);
    push_byte(w[7:0], 1'b0);
  endtask

  // Enter the data section, or close the frame at once when it is empty.
  task automatic open_data();
    if (kept_data_len != 0) begin
      seg      = SEG_DATA;
      seg_left = kept_data_len;
    end else begin
      push_word(CHECKSUM_WORD);
      push_byte(close_byte, 1'b1);
      seg      = SEG_IDLE;
      seg_left = '0;
    end
  endtask

  task automatic finish_name();
    push_word(kept_err);
    push_word(32'(kept_text_len));
    if (kept_text_len != 0) begin
      seg      = SEG_TEXT;
      seg_left = 17'(kept_text_len);
    end else begin
      open_data();
    end
  endtask

  task automatic report(input string what, input logic [7:0] want, input logic [7:0] got);
    err_n++;
    $display("%0t ns: %s mismatch, expected %02h, actual %02h", $time, what, want, got);
  endtask

  always @(posedge clk) begin : watch
    logic [31:0] id;
    logic [31:0] ec;
    logic [31:0] total;
    logic [9:0]  nl;
    logic [9:0]  tl;
    logic [15:0] dl;
    logic [7:0]  pb;
    frame_byte_t want;
    if (!rst_n) begin
      bytes_due.delete();
      seg           = SEG_IDLE;
      seg_left      = '0;
      kept_err      = '0;
      kept_text_len = '0;
      kept_data_len = '0;
      open_byte     = START_BYTE_RST;
      close_byte    = END_BYTE_RST;
      err_n         = 0;
      byte_n        = 0;
      frame_n       = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_START_BYTE)
          open_byte = cfg_data;
        else if (cfg_index == REG_END_BYTE)
          close_byte = cfg_data;
      end

      if (in_tvalid && in_tready) begin
        id = in_tdata[31:0];
        ec = in_tdata[63:32];
        nl = in_tdata[73:64];
        tl = in_tdata[83:74];
        dl = in_tdata[99:84];
        pb = in_tdata[107:100];
        if (in_tuser == OP_HEADER) begin
          if (seg == SEG_IDLE && int'(tl) <= MAX_TEXT_LEN && int'(dl) <= MAX_DATA_LEN) begin
            kept_err      = ec;
            kept_text_len = tl;
            kept_data_len = 17'(dl);
            total = 32'(FIXED_OVERHEAD) + 32'(nl) + 32'(tl) + 32'(dl);
            push_byte(open_byte, 1'b0);
            push_word(total);
            push_word(id);
            push_word(32'(nl));
            if (nl != 0) begin
              seg      = SEG_NAME;
              seg_left = 17'(nl);
            end else begin
              finish_name();
            end
          end
        end else if (seg != SEG_IDLE) begin
          push_byte(pb, 1'b0);
          if (seg_left != 0)
            seg_left = seg_left - 17'd1;
          if (seg_left == 0) begin
            case (seg)
              SEG_NAME: begin
                finish_name();
              end
              SEG_TEXT: begin
                open_data();
              end
              default: begin
                kept_data_len = '0;
                open_data();
              end
            endcase
          end
        end
      end

      if (out_tvalid && out_tready) begin
        byte_n++;
        if (out_tlast)
          frame_n++;
        if (bytes_due.size() == 0) begin
          report("unexpected byte (none due)", 8'h00, out_tdata);
        end else begin
          want = bytes_due.pop_front();
          if (want.value !== out_tdata)
            report("frame byte", want.value, out_tdata);
          else if (want.last !== out_tlast)
            report("last flag", 8'(want.last), 8'(out_tlast));
        end
      end
    end
    fail_count  <= err_n;
    pending     <= bytes_due.size();
    bytes_seen  <= byte_n;
    frames_seen <= frame_n;
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top: clock, reset, request and register stimulus, and the verdict.
module tb_top;
  import mfe_pkg::*;

  localparam int SETTLE_CYCLES = 40;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic                 in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [7:0]           out_tdata;
  logic                 out_tlast;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  int tx_idle_pct = 38;
  int rx_idle_pct = 67;
  int frames_sent = 0;
  int items_sent  = 0;
  int fail_count;
  int pending;
  int bytes_seen;
  int frames_seen;

  message_frame_encoder dut (.*);

  frame_checker frame_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .bytes_seen  (bytes_seen),
    .frames_seen (frames_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Timed out with %0d frame bytes still due", pending);
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  task automatic send_req(input logic op, input logic [IN_DATA_W-1:0] data);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // Unused fields of each request carry random noise.
  task automatic send_header(input logic [31:0] id, input logic [31:0] ec,
                             input logic [9:0] nl, input logic [9:0] tl,
                             input logic [15:0] dl);
    send_req(OP_HEADER, {4'b0, 8'($urandom), dl, tl, nl, ec, id});
  endtask

  task automatic send_payload(input logic [7:0] pb);
    send_req(OP_PAYLOAD, {4'b0, pb, 16'($urandom), 10'($urandom), 10'($urandom),
                          32'($urandom), 32'($urandom)});
  endtask

  task automatic send_frame(input logic [9:0] nl, input logic [9:0] tl,
                            input logic [15:0] dl, input bit intrude);
    int span;
    int cut;
    span = int'(nl) + int'(tl) + int'(dl);
    cut  = $urandom_range(0, span);
    send_header($urandom, $urandom, nl, tl, dl);
    for (int i = 0; i < span; i++) begin
      if (intrude && i == cut)
        send_header($urandom, $urandom, 10'($urandom), 10'($urandom), 16'($urandom));
      send_payload(8'($urandom));
    end
    frames_sent++;
  endtask

  // Drop valid and wait until every predicted byte has left the block.
  task automatic drain();
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame_marks(input logic [7:0] open_val, input logic [7:0] close_val);
    cfg_valid <= 1'b1;
    cfg_index <= REG_START_BYTE;
    cfg_data  <= open_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_END_BYTE;
    cfg_data  <= close_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int tx, input int rx, input int quota);
    int          base;
    int          pick;
    int          cap;
    logic [9:0]  nl;
    logic [9:0]  tl;
    logic [15:0] dl;
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    base = items_sent;
    while (items_sent - base < quota) begin
      pick = $urandom_range(0, 99);
      cap  = ($urandom_range(0, 9) == 0) ? 40 : 6;
      nl   = 10'($urandom_range(0, cap));
      tl   = 10'($urandom_range(0, cap));
      dl   = 16'($urandom_range(0, cap));
      if (pick < 88)
        send_frame(nl, tl, dl, pick >= 80);
      else if (pick < 94)
        send_header($urandom, $urandom, nl, 10'($urandom_range(MAX_TEXT_LEN + 1, 1023)), dl);
      else
        repeat ($urandom_range(1, 3)) send_payload(8'($urandom));
    end
    drain();
  endtask

  initial begin
    in_tvalid  = 1'b0;
    in_tuser   = OP_HEADER;
    in_tdata   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_START_BYTE;
    cfg_data   = '0;
    rst_n      = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests under the reset start and end bytes.
    send_payload(8'hFF);
    send_header(32'hFFFF_FFFF, 32'h8000_0000, 10'd0, 10'd0, 16'd0);
    send_header(32'h1234_5678, 32'h0000_0001, 10'd5, 10'(MAX_TEXT_LEN + 1), 16'd0);
    send_header(32'h0000_0000, 32'hFFFF_FFFF, 10'd0, 10'd1023, 16'hFFFF);
    send_header(32'h0000_0000, 32'h7FFF_FFFF, 10'd1, 10'd1, 16'd1);
    send_header(32'hDEAD_BEEF, 32'h0000_0000, 10'd2, 10'd2, 16'd2);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_payload(8'hA5);
    send_header(32'h0F0F_0F0F, 32'hFFFF_FFFE, 10'd0, 10'd2, 16'd0);
    send_payload(8'h5A);
    send_payload(8'h80);
    send_header(32'hF0F0_F0F0, 32'h8000_0001, 10'd2, 10'd0, 16'd1);
    send_payload(8'h01);
    send_payload(8'h7F);
    send_payload(8'hFE);
    send_header(32'h8000_0000, 32'h0000_00FF, 10'd0, 10'd0, 16'd3);
    send_payload(8'h55);
    send_payload(8'hAA);
    send_payload(8'hC3);
    send_payload(8'h00);
    frames_sent += 5;
    drain();

    write_frame_marks(8'h00, 8'hFF);
    run_phase(38, 67, 100);
    write_frame_marks(8'hFF, 8'h00);
    run_phase(67, 38, 100);
    write_frame_marks(8'($urandom), 8'($urandom));
    run_phase(0, 0, 100);

    $display("Sent %0d frames in %0d requests across three handshake idling profiles",
             frames_sent, items_sent);
    $display("and four start/end byte settings; checked %0d bytes and %0d frame ends",
             bytes_seen, frames_seen);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
